[hdl/akfr_pkg.sv]
// Shared types and constants for the acknowledgement frame receiver with retry.
// Holds operation and event codes, register indexes and the configuration struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package akfr_pkg;

  // Operation codes of an input word
  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_BYTE  = 2'd1,
    OP_TICK  = 2'd2,
    OP_NONE  = 2'd3
  } akfr_op_t;

  // Event codes of a result word
  typedef enum logic [1:0] {
    EV_SEND = 2'd0,
    EV_REF1 = 2'd1,
    EV_REF2 = 2'd2,
    EV_FAIL = 2'd3
  } akfr_ev_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_FLAG_BYTE     = 3'd0,
    REG_REF1_ADDRESS  = 3'd1,
    REG_REF1_CONTROL  = 3'd2,
    REG_REF2_ENABLE   = 3'd3,
    REG_REF2_ADDRESS  = 3'd4,
    REG_REF2_CONTROL  = 3'd5,
    REG_TIMEOUT_TICKS = 3'd6,
    REG_MAX_TRIES     = 3'd7
  } akfr_reg_t;

  // Reset values of the registers
  localparam logic [7:0] FLAG_BYTE_RST     = 8'd126;
  localparam logic [7:0] REF1_ADDRESS_RST  = 8'd3;
  localparam logic [7:0] REF1_CONTROL_RST  = 8'd7;
  localparam logic       REF2_ENABLE_RST   = 1'b0;
  localparam logic [7:0] REF2_ADDRESS_RST  = 8'd1;
  localparam logic [7:0] REF2_CONTROL_RST  = 8'd11;
  localparam logic [7:0] TIMEOUT_TICKS_RST = 8'd3;
  localparam logic [3:0] MAX_TRIES_RST     = 4'd3;

  // Register file contents as seen by the datapath
  typedef struct packed {
    logic [7:0] flag_byte;
    logic [7:0] ref1_address;
    logic [7:0] ref1_control;
    logic       ref2_enable;
    logic [7:0] ref2_address;
    logic [7:0] ref2_control;
    logic [7:0] timeout_ticks;
    logic [3:0] max_tries;
  } akfr_cfg_t;

endpackage : akfr_pkg

`default_nettype wire

[hdl/akfr_cfg_regs.sv]
// Configuration register file of the acknowledgement frame receiver.
// Depends on akfr_pkg for register indexes, reset values and the config struct.
`timescale 1ns / 1ps
`default_nettype none

module akfr_cfg_regs
  import akfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       wr_en,
  input  wire logic [2:0] wr_index,
  input  wire logic [7:0] wr_data,
  output akfr_cfg_t       cfg
);

  akfr_cfg_t cfg_r;
  akfr_cfg_t cfg_nxt;

  // Decode one register write
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (akfr_reg_t'(wr_index))
        REG_FLAG_BYTE:     cfg_nxt.flag_byte     = wr_data;
        REG_REF1_ADDRESS:  cfg_nxt.ref1_address  = wr_data;
        REG_REF1_CONTROL:  cfg_nxt.ref1_control  = wr_data;
        REG_REF2_ENABLE:   cfg_nxt.ref2_enable   = wr_data[0];
        REG_REF2_ADDRESS:  cfg_nxt.ref2_address  = wr_data;
        REG_REF2_CONTROL:  cfg_nxt.ref2_control  = wr_data;
        REG_TIMEOUT_TICKS: cfg_nxt.timeout_ticks = wr_data;
        REG_MAX_TRIES:     cfg_nxt.max_tries     = wr_data[3:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flag_byte     <= FLAG_BYTE_RST;
      cfg_r.ref1_address  <= REF1_ADDRESS_RST;
      cfg_r.ref1_control  <= REF1_CONTROL_RST;
      cfg_r.ref2_enable   <= REF2_ENABLE_RST;
      cfg_r.ref2_address  <= REF2_ADDRESS_RST;
      cfg_r.ref2_control  <= REF2_CONTROL_RST;
      cfg_r.timeout_ticks <= TIMEOUT_TICKS_RST;
      cfg_r.max_tries     <= MAX_TRIES_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule : akfr_cfg_regs

`default_nettype wire

[hdl/akfr_frame_rx.sv]
// Five-phase frame receiver: flag, address, control, BCC, flag.
// Depends on akfr_pkg for the config struct type of the cfg port.
`timescale 1ns / 1ps
`default_nettype none

module akfr_frame_rx
  import akfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       byte_en,    // one received byte to consume
  input  wire logic       clear,      // back to awaiting flag
  input  wire logic [7:0] rx_byte,
  input  akfr_cfg_t       cfg,
  output logic            frame_done, // closing flag seen this byte
  output logic [7:0]      held_address,
  output logic [7:0]      held_control
);

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_ADDR  = 3'd1,
    PH_CTRL  = 3'd2,
    PH_BCC   = 3'd3,
    PH_CLOSE = 3'd4
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] addr_r, addr_nxt;
  logic [7:0] ctrl_r, ctrl_nxt;
  logic       is_flag;

  assign is_flag = (rx_byte == cfg.flag_byte);

  // Phase decode for one byte
  always_comb begin
    phase_nxt  = phase_r;
    addr_nxt   = addr_r;
    ctrl_nxt   = ctrl_r;
    frame_done = 1'b0;
    if (clear) begin
      phase_nxt = PH_START;
    end else if (byte_en) begin
      case (phase_r)
        PH_START: begin
          if (is_flag) phase_nxt = PH_ADDR;
        end
        PH_ADDR: begin
          if (!is_flag) begin
            addr_nxt  = rx_byte;
            phase_nxt = PH_CTRL;
          end
        end
        PH_CTRL: begin
          if (is_flag) begin
            phase_nxt = PH_ADDR;
          end else begin
            ctrl_nxt  = rx_byte;
            phase_nxt = PH_BCC;
          end
        end
        PH_BCC: begin
          if (is_flag)                           phase_nxt = PH_ADDR;
          else if (rx_byte == (addr_r ^ ctrl_r)) phase_nxt = PH_CLOSE;
          else                                   phase_nxt = PH_START;
        end
        PH_CLOSE: begin
          phase_nxt  = PH_START;
          frame_done = is_flag;
        end
        default: phase_nxt = PH_START;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      addr_r  <= 8'd0;
      ctrl_r  <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      addr_r  <= addr_nxt;
      ctrl_r  <= ctrl_nxt;
    end
  end

  assign held_address = addr_r;
  assign held_control = ctrl_r;

  // A frame completes only out of the closing-flag phase
  a_done_from_close: assert property (@(posedge clk) disable iff (!rst_n)
    frame_done |-> (phase_r == PH_CLOSE) && byte_en && !clear)
    else $error("frame completed outside closing phase");

  // After a clear the receiver awaits a flag
  a_clear_to_start: assert property (@(posedge clk) disable iff (!rst_n)
    clear |=> (phase_r == PH_START))
    else $error("receiver not back at start after clear");

  // Closing phase is reached only with a good BCC
  a_close_bcc: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_en && !clear && phase_r == PH_BCC && !is_flag && rx_byte != (addr_r ^ ctrl_r))
      |=> (phase_r == PH_START))
    else $error("bad BCC did not reset receiver");

endmodule : akfr_frame_rx

`default_nettype wire

[hdl/ack_frame_receiver_with_retry_top.sv]
// Top level of the stop-and-wait acknowledgement receiver with retry.
// Depends on akfr_pkg, akfr_cfg_regs and akfr_frame_rx.
//
// Usage:
//   Input channel (in_valid/in_ready): one word per command, in_operation
//   0 = start send, 1 = received byte in in_rx_byte, 2 = timer tick.
//   Result channel (out_valid/out_ready): out_event_res 0 = transmit frame,
//   1 = reference 1 matched, 2 = reference 2 matched, 3 = failed.
//   Many words give no result; a word gives at most one.
//   Config channel (cfg_valid/cfg_ready): cfg_index selects one of eight
//   registers, cfg_data is the value; always ready. Write only while idle.
// Timing:
//   A word is registered on accept and processed once the output register can
//   take its result, which is registered there. One word per cycle is sustained
//   while results are taken, set by the single input and output register pair.
// Reset (rst_n low, synchronous): registers to defaults, idle, no result.
// Stall: a held result that is not taken blocks processing of the next
//   word; in_ready drops once the input register is also full.
`timescale 1ns / 1ps
`default_nettype none

module ack_frame_receiver_with_retry_top
  import akfr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_operation,
  input  wire logic [7:0] in_rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [1:0]      out_event_res,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  akfr_cfg_t  cfg;

  // Input register
  logic       item_valid_r;
  akfr_op_t   op_r;
  logic [7:0] byte_r;
  logic       proc_go;

  // Exchange state
  logic       waiting_r, waiting_nxt;
  logic [3:0] tries_r, tries_nxt;
  logic [7:0] idle_r, idle_nxt;
  logic [7:0] idle_inc;

  // Result
  logic       res_valid;
  akfr_ev_t   res_ev;
  logic       out_valid_r;
  akfr_ev_t   out_ev_r;

  // Receiver hookup
  logic       rx_byte_en, rx_clear, frame_done;
  logic [7:0] held_address, held_control;
  logic       match1, match2;

  assign cfg_ready = 1'b1;

  akfr_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Process the held word when the result register can take a result
  assign proc_go  = item_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !item_valid_r || proc_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      item_valid_r <= 1'b1;
      op_r         <= akfr_op_t'(in_operation);
      byte_r       <= in_rx_byte;
    end else if (proc_go) begin
      item_valid_r <= 1'b0;
    end
  end

  akfr_frame_rx u_frame_rx (
    .clk          (clk),
    .rst_n        (rst_n),
    .byte_en      (rx_byte_en),
    .clear        (rx_clear),
    .rx_byte      (byte_r),
    .cfg          (cfg),
    .frame_done   (frame_done),
    .held_address (held_address),
    .held_control (held_control)
  );

  assign idle_inc = idle_r + 8'd1;
  assign match1   = (held_address == cfg.ref1_address) && (held_control == cfg.ref1_control);
  assign match2   = cfg.ref2_enable && (held_address == cfg.ref2_address)
                    && (held_control == cfg.ref2_control);

  // Exchange control for one word
  always_comb begin
    waiting_nxt = waiting_r;
    tries_nxt   = tries_r;
    idle_nxt    = idle_r;
    rx_byte_en  = 1'b0;
    rx_clear    = 1'b0;
    res_valid   = 1'b0;
    res_ev      = EV_SEND;
    if (proc_go) begin
      case (op_r)
        OP_START: begin
          rx_clear  = 1'b1;
          idle_nxt  = 8'd0;
          res_valid = 1'b1;
          if (cfg.max_tries == 4'd0) begin
            waiting_nxt = 1'b0;
            tries_nxt   = 4'd0;
            res_ev      = EV_FAIL;
          end else begin
            waiting_nxt = 1'b1;
            tries_nxt   = 4'd1;
            res_ev      = EV_SEND;
          end
        end
        OP_BYTE: begin
          if (waiting_r) begin
            idle_nxt   = 8'd0;
            rx_byte_en = 1'b1;
            if (frame_done && match1) begin
              waiting_nxt = 1'b0;
              res_valid   = 1'b1;
              res_ev      = EV_REF1;
            end else if (frame_done && match2) begin
              waiting_nxt = 1'b0;
              res_valid   = 1'b1;
              res_ev      = EV_REF2;
            end
          end
        end
        OP_TICK: begin
          if (waiting_r) begin
            if (idle_inc < cfg.timeout_ticks) begin
              idle_nxt = idle_inc;
            end else begin
              // timeout: resend or give up
              idle_nxt  = 8'd0;
              rx_clear  = 1'b1;
              res_valid = 1'b1;
              if (tries_r < cfg.max_tries) begin
                tries_nxt = tries_r + 4'd1;
                res_ev    = EV_SEND;
              end else begin
                waiting_nxt = 1'b0;
                res_ev      = EV_FAIL;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      waiting_r <= 1'b0;
      tries_r   <= 4'd0;
      idle_r    <= 8'd0;
    end else begin
      waiting_r <= waiting_nxt;
      tries_r   <= tries_nxt;
      idle_r    <= idle_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_go && res_valid) begin
      out_valid_r <= 1'b1;
      out_ev_r    <= res_ev;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_event_res = out_ev_r;

  // Results other than start only come while waiting
  a_result_needs_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_go && res_valid) |-> (op_r == OP_START) || waiting_r)
    else $error("result produced while idle");

  // Match results come only from a completed frame
  a_match_from_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_go && res_valid && (res_ev == EV_REF1 || res_ev == EV_REF2))
      |-> (op_r == OP_BYTE) && frame_done)
    else $error("match reported without a complete frame");

  // A failure or match ends the wait
  a_end_of_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (proc_go && res_valid && res_ev != EV_SEND) |=> !waiting_r)
    else $error("still waiting after final result");

  // Input stalls only with both registers full
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> item_valid_r && out_valid_r && !out_ready)
    else $error("input stalled without a full pipeline");

endmodule : ack_frame_receiver_with_retry_top

`default_nettype wire
